// ===== design/psg_adsr_envelope_core_assert.svh =====
// Assertion macros used by the checker file.
`ifndef PSG_ADSR_ENVELOPE_CORE_ASSERT_SVH
`define PSG_ADSR_ENVELOPE_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define PSGADSR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("envelope check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define PSGADSR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("envelope check failed");

`endif

// ===== design/psgadsr_pkg.sv =====
package psgadsr_pkg;

    // Field widths
    localparam int REQ_W   = 2;
    localparam int RATE_W  = 4;
    localparam int LVL_W   = 4;
    localparam int VEL_W   = 7;
    localparam int VOLIN_W = 7;
    localparam int CODE_W  = 3;
    localparam int VOUT_W  = 4;

    // Signed working width for the level arithmetic (covers -15 .. 30)
    localparam int WORK_W = 7;
    localparam logic signed [WORK_W-1:0] WORK_ZERO = '0;

    // Volume product chain: track * player, * velocity, * level
    localparam int PROD_A_W  = 2 * VOLIN_W;
    localparam int PROD_B_W  = PROD_A_W + VEL_W;
    localparam int PROD_C_W  = PROD_B_W + LVL_W;
    localparam int VOL_SHIFT = 21;

    localparam logic [LVL_W-1:0] LEVEL_PEAK = 4'd15;

    // Request kinds
    localparam logic [REQ_W-1:0] REQ_TICK     = 2'd0;
    localparam logic [REQ_W-1:0] REQ_NOTE_ON  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_NOTE_OFF = 2'd2;

    // Phase codes as reported on the result
    localparam logic [CODE_W-1:0] CODE_IDLE    = 3'd0;
    localparam logic [CODE_W-1:0] CODE_ARMED   = 3'd1;
    localparam logic [CODE_W-1:0] CODE_ATTACK  = 3'd2;
    localparam logic [CODE_W-1:0] CODE_DECAY   = 3'd3;
    localparam logic [CODE_W-1:0] CODE_SUSTAIN = 3'd4;
    localparam logic [CODE_W-1:0] CODE_RELEASE = 3'd5;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [5:0] {
        PH_IDLE    = 6'b000001,
        PH_ARMED   = 6'b000010,
        PH_ATTACK  = 6'b000100,
        PH_DECAY   = 6'b001000,
        PH_SUSTAIN = 6'b010000,
        PH_RELEASE = 6'b100000
    } env_phase_t;

    // One queued request: envelope state after the request plus volume inputs
    typedef struct packed {
        logic [CODE_W-1:0]  phase_code;
        logic [LVL_W-1:0]   level;
        logic               active;
        logic [VOLIN_W-1:0] track_volume;
        logic [VOLIN_W-1:0] player_volume;
        logic [VEL_W-1:0]   velocity;
    } env_entry_t;

    function automatic logic [CODE_W-1:0] phase_code(input env_phase_t ph);
        logic [CODE_W-1:0] code;
        case (ph)
            PH_IDLE:    code = CODE_IDLE;
            PH_ARMED:   code = CODE_ARMED;
            PH_ATTACK:  code = CODE_ATTACK;
            PH_DECAY:   code = CODE_DECAY;
            PH_SUSTAIN: code = CODE_SUSTAIN;
            PH_RELEASE: code = CODE_RELEASE;
            default:    code = CODE_IDLE;
        endcase
        return code;
    endfunction

endpackage

// ===== design/psg_adsr_envelope_core.sv =====
// Envelope generator for one tone-generator voice.
// Input channel (in_valid / in_ready) carries one request: req_type selects
// tick, note on or note off; rates, sustain and velocity matter on note on,
// track and player volume on every request. Output channel (out_valid /
// out_ready) returns exactly one result per request, in order: phase code,
// envelope level, scaled volume and the active flag.
// The front steps the envelope state in the cycle a request is accepted and
// queues the result state (two entries). The back pops one entry and runs
// three multiply steps (track*player, *velocity, *level), registering the
// first two and loading the output register on the last. With an empty
// back end, an accepted request moves through the queue, the entry register,
// both product registers and the output register. The back pops no new entry
// until it has loaded the output; the queue absorbs up to two more requests.
// When the receiver stalls, the finished result holds in the output
// register, the back holds its next result, then the queue fills and
// in_ready drops. Reset (rst_n low, asynchronous) returns the voice to
// idle with level 0 and clears the held rates and velocity.
module psg_adsr_envelope_core
    import psgadsr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [REQ_W-1:0]   req_type,
    input  logic [RATE_W-1:0]  attack_rate,
    input  logic [RATE_W-1:0]  decay_rate,
    input  logic [LVL_W-1:0]   sustain_level,
    input  logic [RATE_W-1:0]  release_rate,
    input  logic [VEL_W-1:0]   note_velocity,
    input  logic [VOLIN_W-1:0] track_volume,
    input  logic [VOLIN_W-1:0] player_volume,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [CODE_W-1:0]  phase,
    output logic [LVL_W-1:0]   level,
    output logic [VOUT_W-1:0]  out_volume,
    output logic               active
);

    env_entry_t push_entry;
    env_entry_t head_entry;
    logic       push;
    logic       pop;
    logic       queue_full;
    logic       queue_empty;

    psgadsr_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .req_type      (req_type),
        .attack_rate   (attack_rate),
        .decay_rate    (decay_rate),
        .sustain_level (sustain_level),
        .release_rate  (release_rate),
        .note_velocity (note_velocity),
        .track_volume  (track_volume),
        .player_volume (player_volume),
        .queue_full    (queue_full),
        .push          (push),
        .push_entry    (push_entry)
    );

    psgadsr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head_entry (head_entry),
        .full       (queue_full),
        .empty      (queue_empty)
    );

    psgadsr_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_entry  (head_entry),
        .queue_empty (queue_empty),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .phase       (phase),
        .level       (level),
        .out_volume  (out_volume),
        .active      (active)
    );

endmodule

// ===== design/psgadsr_queue.sv =====
module psgadsr_queue
    import psgadsr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  env_entry_t push_entry,
    input  logic       pop,
    output env_entry_t head_entry,
    output logic       full,
    output logic       empty
);

    env_entry_t          slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;

    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty      = (count_reg == '0);
    assign head_entry = slot_reg[rd_ptr_reg];

    // Advance pointers with wrap, track fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            if (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1))
                wr_ptr_next = '0;
            else
                wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            if (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1))
                rd_ptr_next = '0;
            else
                rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the incoming request
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_entry;
    end

endmodule

// ===== design/psgadsr_front.sv =====
module psgadsr_front
    import psgadsr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [REQ_W-1:0]   req_type,
    input  logic [RATE_W-1:0]  attack_rate,
    input  logic [RATE_W-1:0]  decay_rate,
    input  logic [LVL_W-1:0]   sustain_level,
    input  logic [RATE_W-1:0]  release_rate,
    input  logic [VEL_W-1:0]   note_velocity,
    input  logic [VOLIN_W-1:0] track_volume,
    input  logic [VOLIN_W-1:0] player_volume,
    input  logic               queue_full,
    output logic               push,
    output env_entry_t         push_entry
);

    env_phase_t         phase_reg, phase_next;
    logic               off_reg, off_next;
    logic [LVL_W-1:0]   level_reg, level_next;
    logic [RATE_W-1:0]  attack_reg, attack_next;
    logic [RATE_W-1:0]  decay_reg, decay_next;
    logic [LVL_W-1:0]   sustain_reg, sustain_next;
    logic [RATE_W-1:0]  release_reg, release_next;
    logic [VEL_W-1:0]   velocity_reg, velocity_next;

    logic signed [WORK_W-1:0] work;
    logic signed [WORK_W-1:0] attack_s, decay_s, sustain_s, release_s;
    logic                     done;
    logic                     active_now, active_next;

    assign in_ready = !queue_full;
    assign push     = in_valid && in_ready;

    assign attack_s  = signed'({{(WORK_W-RATE_W){1'b0}}, attack_reg});
    assign decay_s   = signed'({{(WORK_W-RATE_W){1'b0}}, decay_reg});
    assign sustain_s = signed'({{(WORK_W-LVL_W){1'b0}}, sustain_reg});
    assign release_s = signed'({{(WORK_W-RATE_W){1'b0}}, release_reg});

    assign active_now  = phase_reg inside {PH_ATTACK, PH_DECAY, PH_SUSTAIN, PH_RELEASE};
    assign active_next = phase_next inside {PH_ATTACK, PH_DECAY, PH_SUSTAIN, PH_RELEASE};

    // Classify the request and step the envelope
    always_comb
    begin
        phase_next    = phase_reg;
        off_next      = off_reg;
        attack_next   = attack_reg;
        decay_next    = decay_reg;
        sustain_next  = sustain_reg;
        release_next  = release_reg;
        velocity_next = velocity_reg;
        work          = signed'({{(WORK_W-LVL_W){1'b0}}, level_reg});
        done          = 1'b0;

        case (req_type)
            REQ_TICK:
            begin
                if (phase_reg == PH_ARMED)
                begin
                    if (attack_reg != '0)
                    begin
                        work       = '0;
                        phase_next = PH_ATTACK;
                    end
                    else if (decay_reg != '0)
                    begin
                        work       = signed'({{(WORK_W-LVL_W){1'b0}}, LEVEL_PEAK});
                        phase_next = PH_DECAY;
                    end
                    else
                    begin
                        work       = sustain_s;
                        phase_next = PH_SUSTAIN;
                    end
                end
                else if (!active_now)
                begin
                    phase_next = PH_IDLE;
                    off_next   = 1'b0;
                    work       = '0;
                end
                else
                begin
                    // Enter release or cut on a pending note off
                    if (off_reg)
                    begin
                        off_next = 1'b0;
                        if (release_reg == '0)
                        begin
                            phase_next = PH_IDLE;
                            work       = '0;
                            done       = 1'b1;
                        end
                        else
                            phase_next = PH_RELEASE;
                    end
                    if (!done && phase_next == PH_ATTACK)
                    begin
                        work = work + attack_s;
                        if (work > signed'({{(WORK_W-LVL_W){1'b0}}, LEVEL_PEAK}))
                        begin
                            work       = signed'({{(WORK_W-LVL_W){1'b0}}, LEVEL_PEAK});
                            phase_next = (decay_reg != '0) ? PH_DECAY : PH_SUSTAIN;
                        end
                    end
                    if (!done && phase_next == PH_DECAY)
                    begin
                        work = work - decay_s;
                        if (work <= WORK_ZERO)
                        begin
                            phase_next = PH_IDLE;
                            off_next   = 1'b0;
                            work       = '0;
                            done       = 1'b1;
                        end
                        else if (work <= sustain_s)
                            phase_next = PH_SUSTAIN;
                    end
                    if (!done && phase_next == PH_SUSTAIN)
                        work = sustain_s;
                    if (!done && phase_next == PH_RELEASE)
                    begin
                        work = work - release_s;
                        if (work <= WORK_ZERO)
                        begin
                            phase_next = PH_IDLE;
                            off_next   = 1'b0;
                            work       = '0;
                        end
                    end
                end
            end
            REQ_NOTE_ON:
            begin
                attack_next   = attack_rate;
                decay_next    = decay_rate;
                sustain_next  = sustain_level;
                release_next  = release_rate;
                velocity_next = note_velocity;
                off_next      = 1'b0;
                phase_next    = PH_ARMED;
            end
            REQ_NOTE_OFF:
            begin
                if (active_now)
                    off_next = 1'b1;
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase

        // Clamp the level into its field range
        if (work < WORK_ZERO)
            level_next = '0;
        else if (work > signed'({{(WORK_W-LVL_W){1'b0}}, LEVEL_PEAK}))
            level_next = LEVEL_PEAK;
        else
            level_next = work[LVL_W-1:0];
    end

    // Build the queued request from the new state
    always_comb
    begin
        push_entry.phase_code    = phase_code(phase_next);
        push_entry.level         = level_next;
        push_entry.active        = active_next;
        push_entry.track_volume  = track_volume;
        push_entry.player_volume = player_volume;
        push_entry.velocity      = velocity_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            off_reg      <= 1'b0;
            level_reg    <= '0;
            attack_reg   <= '0;
            decay_reg    <= '0;
            sustain_reg  <= '0;
            release_reg  <= '0;
            velocity_reg <= '0;
        end
        else if (push)
        begin
            phase_reg    <= phase_next;
            off_reg      <= off_next;
            level_reg    <= level_next;
            attack_reg   <= attack_next;
            decay_reg    <= decay_next;
            sustain_reg  <= sustain_next;
            release_reg  <= release_next;
            velocity_reg <= velocity_next;
        end
    end

endmodule

// ===== design/psgadsr_back.sv =====
module psgadsr_back
    import psgadsr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  env_entry_t        head_entry,
    input  logic              queue_empty,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [CODE_W-1:0] phase,
    output logic [LVL_W-1:0]  level,
    output logic [VOUT_W-1:0] out_volume,
    output logic              active
);

    typedef enum logic [3:0] {
        B_IDLE = 4'b0001,
        B_MUL1 = 4'b0010,
        B_MUL2 = 4'b0100,
        B_MUL3 = 4'b1000
    } back_state_t;

    back_state_t          state_reg, state_next;
    env_entry_t           entry_reg;
    logic [PROD_A_W-1:0]  prod_a_reg;
    logic [PROD_B_W-1:0]  prod_b_reg;
    logic [PROD_C_W-1:0]  prod_c;
    logic                 out_valid_reg, out_valid_next;
    logic [CODE_W-1:0]    phase_reg;
    logic [LVL_W-1:0]     level_reg;
    logic [VOUT_W-1:0]    volume_reg;
    logic                 active_reg;
    logic                 load;

    assign pop    = (state_reg == B_IDLE) && !queue_empty;
    assign load   = (state_reg == B_MUL3) && (!out_valid_reg || out_ready);
    assign prod_c = PROD_C_W'(prod_b_reg) * PROD_C_W'(entry_reg.level);

    // Sequence the three multiply steps; hold the last one until the output register can be loaded
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:  if (!queue_empty) state_next = B_MUL1;
            B_MUL1:  state_next = B_MUL2;
            B_MUL2:  state_next = B_MUL3;
            B_MUL3:  if (load) state_next = B_IDLE;
            default: state_next = B_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the request, run the product chain and load the output register
    always_ff @(posedge clk)
    begin
        if (pop)
            entry_reg <= head_entry;
        if (state_reg == B_MUL1)
            prod_a_reg <= PROD_A_W'(entry_reg.track_volume)
                        * PROD_A_W'(entry_reg.player_volume);
        if (state_reg == B_MUL2)
            prod_b_reg <= PROD_B_W'(prod_a_reg) * PROD_B_W'(entry_reg.velocity);
        if (load)
        begin
            phase_reg  <= entry_reg.phase_code;
            level_reg  <= entry_reg.level;
            active_reg <= entry_reg.active;
            if (!entry_reg.active)
                volume_reg <= '0;
            else if (prod_c[PROD_C_W-1:VOL_SHIFT] > (PROD_C_W-VOL_SHIFT)'(LEVEL_PEAK))
                volume_reg <= VOUT_W'(LEVEL_PEAK);
            else
                volume_reg <= VOUT_W'(prod_c[PROD_C_W-1:VOL_SHIFT]);
        end
    end

    assign out_valid  = out_valid_reg;
    assign phase      = phase_reg;
    assign level      = level_reg;
    assign out_volume = volume_reg;
    assign active     = active_reg;

endmodule

// ===== design/psgadsr_checker.sv =====
`include "psg_adsr_envelope_core_assert.svh"

module psgadsr_checker
    import psgadsr_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_ready,
    input logic [CODE_W-1:0]  phase,
    input logic [LVL_W-1:0]   level,
    input logic [VOUT_W-1:0]  out_volume,
    input logic               active
);

    // Silent voice reports zero volume
    `PSGADSR_ASSERT_NOW(a_quiet_when_inactive, out_valid && !active, out_volume == '0)

    // Active flag agrees with the sounding phases
    `PSGADSR_ASSERT_NOW(a_active_matches_phase, out_valid,
        active == (phase == CODE_ATTACK || phase == CODE_DECAY ||
                   phase == CODE_SUSTAIN || phase == CODE_RELEASE))

    // Idle voice sits at level zero
    `PSGADSR_ASSERT_NOW(a_idle_level_zero, out_valid && phase == CODE_IDLE, level == '0)

    // Hold a stalled result
    `PSGADSR_ASSERT_NEXT(a_stall_holds, out_valid && !out_ready,
        out_valid && $stable(phase) && $stable(level) && $stable(out_volume))

endmodule

bind psg_adsr_envelope_core psgadsr_checker u_psgadsr_checker (.*);

// ===== dv/psg_adsr_envelope_core_tb.sv =====
`timescale 1ns / 1ps

module psg_adsr_envelope_core_tb;
    import psgadsr_pkg::*;

    // Request code that the block must ignore
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

    localparam int LONG_HOLD   = 150;
    localparam int QUIET_LIMIT = 2000;
    localparam int DRAIN_WAIT  = 20;
    localparam int PHASE_ITEMS = 200;

    typedef enum int {RECV_SLOW, SEND_SLOW, NO_IDLE} pace_t;

    typedef struct {
        logic [REQ_W-1:0]   kind;
        logic [RATE_W-1:0]  attack;
        logic [RATE_W-1:0]  decay;
        logic [LVL_W-1:0]   sustain;
        logic [RATE_W-1:0]  release_step;
        logic [VEL_W-1:0]   velocity;
        logic [VOLIN_W-1:0] track;
        logic [VOLIN_W-1:0] player;
    } env_req_t;

    typedef struct {
        logic [CODE_W-1:0] phase;
        logic [LVL_W-1:0]  level;
        logic [VOUT_W-1:0] volume;
        logic              active;
    } env_result_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [REQ_W-1:0]   req_type = '0;
    logic [RATE_W-1:0]  attack_rate = '0;
    logic [RATE_W-1:0]  decay_rate = '0;
    logic [LVL_W-1:0]   sustain_level = '0;
    logic [RATE_W-1:0]  release_rate = '0;
    logic [VEL_W-1:0]   note_velocity = '0;
    logic [VOLIN_W-1:0] track_volume = '0;
    logic [VOLIN_W-1:0] player_volume = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [CODE_W-1:0]  phase;
    logic [LVL_W-1:0]   level;
    logic [VOUT_W-1:0]  out_volume;
    logic               active;

    env_req_t    request_backlog[$];
    env_result_t predicted_results[$];

    pace_t pace = RECV_SLOW;
    int    queued_count = 0;
    int    offered_count = 0;
    int    accepted_count = 0;
    int    results_seen = 0;
    int    error_count = 0;
    int    quiet_cycles = 0;
    int    hold_requests = 0;
    int    holds_started = 0;
    int    hold_left = 0;
    int    kind_seen[4] = '{0, 0, 0, 0};

    // Envelope state mirrored from the accepted request stream
    logic [CODE_W-1:0] env_code = CODE_IDLE;
    logic              off_pending = 1'b0;
    int                env_level = 0;
    logic [RATE_W-1:0] held_attack = '0;
    logic [RATE_W-1:0] held_decay = '0;
    logic [LVL_W-1:0]  held_sustain = '0;
    logic [RATE_W-1:0] held_release = '0;
    logic [VEL_W-1:0]  held_velocity = '0;

    psg_adsr_envelope_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .req_type      (req_type),
        .attack_rate   (attack_rate),
        .decay_rate    (decay_rate),
        .sustain_level (sustain_level),
        .release_rate  (release_rate),
        .note_velocity (note_velocity),
        .track_volume  (track_volume),
        .player_volume (player_volume),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .phase         (phase),
        .level         (level),
        .out_volume    (out_volume),
        .active        (active)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic bit roll_gap(input int pct);
        return $urandom_range(99) < pct;
    endfunction

    function automatic bit voice_sounding();
        return env_code >= CODE_ATTACK && env_code <= CODE_RELEASE;
    endfunction

    task automatic silence_voice();
        env_code    = CODE_IDLE;
        off_pending = 1'b0;
        env_level   = 0;
    endtask

    // Advance the envelope by one tick
    task automatic tick_envelope();
        if (env_code == CODE_ARMED)
        begin
            if (held_attack != 0)
            begin
                env_level = 0;
                env_code  = CODE_ATTACK;
            end
            else if (held_decay != 0)
            begin
                env_level = int'(LEVEL_PEAK);
                env_code  = CODE_DECAY;
            end
            else
            begin
                env_level = int'(held_sustain);
                env_code  = CODE_SUSTAIN;
            end
            return;
        end
        if (!voice_sounding())
        begin
            silence_voice();
            return;
        end
        // Enter release on a pending note off, or cut at once with no release rate
        if (off_pending)
        begin
            if (held_release == 0)
            begin
                silence_voice();
                return;
            end
            off_pending = 1'b0;
            env_code    = CODE_RELEASE;
        end
        if (env_code == CODE_ATTACK)
        begin
            env_level += int'(held_attack);
            if (env_level > int'(LEVEL_PEAK))
            begin
                env_level = int'(LEVEL_PEAK);
                env_code  = (held_decay != 0) ? CODE_DECAY : CODE_SUSTAIN;
            end
        end
        if (env_code == CODE_DECAY)
        begin
            env_level -= int'(held_decay);
            if (env_level <= 0)
            begin
                silence_voice();
                return;
            end
            if (env_level <= int'(held_sustain))
                env_code = CODE_SUSTAIN;
        end
        if (env_code == CODE_SUSTAIN)
            env_level = int'(held_sustain);
        if (env_code == CODE_RELEASE)
        begin
            env_level -= int'(held_release);
            if (env_level <= 0)
                silence_voice();
        end
    endtask

    // Apply one request and work out the result it should produce
    task automatic step_envelope(input env_req_t rq, output env_result_t res);
        longint unsigned scaled;
        case (rq.kind)
            REQ_TICK:
                tick_envelope();
            REQ_NOTE_ON:
            begin
                held_attack   = rq.attack;
                held_decay    = rq.decay;
                held_sustain  = rq.sustain;
                held_release  = rq.release_step;
                held_velocity = rq.velocity;
                off_pending   = 1'b0;
                env_code      = CODE_ARMED;
            end
            REQ_NOTE_OFF:
                if (voice_sounding())
                    off_pending = 1'b1;
            default:
                ;
        endcase
        if (env_level < 0)
            env_level = 0;
        if (env_level > int'(LEVEL_PEAK))
            env_level = int'(LEVEL_PEAK);
        scaled = 0;
        if (voice_sounding())
        begin
            scaled = (longint'(rq.track) * longint'(rq.player) * longint'(held_velocity)
                      * longint'(env_level)) >> VOL_SHIFT;
            if (scaled > 15)
                scaled = 15;
        end
        res.phase  = env_code;
        res.level  = env_level[LVL_W-1:0];
        res.volume = scaled[VOUT_W-1:0];
        res.active = voice_sounding();
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            error_count++;
        end
    endtask

    task automatic queue_req(input logic [REQ_W-1:0] kind, input int a, input int d,
                             input int s, input int r, input int v, input int tv,
                             input int pv);
        env_req_t rq;
        rq.kind         = kind;
        rq.attack       = RATE_W'(a);
        rq.decay        = RATE_W'(d);
        rq.sustain      = LVL_W'(s);
        rq.release_step = RATE_W'(r);
        rq.velocity     = VEL_W'(v);
        rq.track        = VOLIN_W'(tv);
        rq.player       = VOLIN_W'(pv);
        request_backlog.push_back(rq);
        queued_count++;
    endtask

    task automatic queue_random(input logic [REQ_W-1:0] kind);
        queue_req(kind, $urandom_range(15), $urandom_range(15), $urandom_range(15),
                  $urandom_range(15), $urandom_range(127), $urandom_range(127),
                  $urandom_range(127));
    endtask

    // Note on, a run of ticks, and usually a note off with its release ticks
    task automatic queue_note_sequence();
        int n;
        queue_random(REQ_NOTE_ON);
        n = $urandom_range(12, 1);
        repeat (n) queue_random(REQ_TICK);
        if ($urandom_range(9) < 7)
        begin
            queue_random(REQ_NOTE_OFF);
            n = $urandom_range(8, 1);
            repeat (n) queue_random(REQ_TICK);
        end
    endtask

    // Hold until every queued request is taken and every result is back
    task automatic wait_drained();
        do
            @(negedge clk);
        while (accepted_count != queued_count || predicted_results.size() != 0);
    endtask

    // Offer requests from the backlog, holding each until it is taken
    always @(negedge clk)
    begin : drive_requests
        env_req_t nxt;
        if (rst_n && accepted_count == offered_count)
        begin
            if (request_backlog.size() != 0
                && !roll_gap(pace == RECV_SLOW ? 33 : pace == SEND_SLOW ? 82 : 0))
            begin
                nxt = request_backlog.pop_front();
                in_valid      <= 1'b1;
                req_type      <= nxt.kind;
                attack_rate   <= nxt.attack;
                decay_rate    <= nxt.decay;
                sustain_level <= nxt.sustain;
                release_rate  <= nxt.release_step;
                note_velocity <= nxt.velocity;
                track_volume  <= nxt.track;
                player_volume <= nxt.player;
                offered_count <= offered_count + 1;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Drive out_ready: long holds on demand, otherwise random stalls
    always @(negedge clk)
    begin : drive_ready
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else if (holds_started != hold_requests)
        begin
            holds_started <= holds_started + 1;
            hold_left     <= LONG_HOLD;
            out_ready     <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= !roll_gap(pace == RECV_SLOW ? 82 : pace == SEND_SLOW ? 33 : 0);
        end
    end

    // Check results, predict accepted requests, and watch for a hang
    always @(posedge clk)
    begin : watch_channels
        env_result_t want;
        env_req_t    got_req;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (predicted_results.size() == 0)
                begin
                    $display("%0t: result with none expected, actual %0d %0d %0d %0d",
                             $time, phase, level, out_volume, active);
                    error_count++;
                end
                else
                begin
                    want = predicted_results.pop_front();
                    check_field("phase", want.phase, phase);
                    check_field("level", want.level, level);
                    check_field("out_volume", want.volume, out_volume);
                    check_field("active", want.active, active);
                end
            end
            if (in_valid && in_ready)
            begin
                got_req = '{req_type, attack_rate, decay_rate, sustain_level, release_rate,
                            note_velocity, track_volume, player_volume};
                step_envelope(got_req, want);
                predicted_results.push_back(want);
                kind_seen[req_type]++;
                accepted_count <= accepted_count + 1;
            end
            if ((in_valid && in_ready) || (out_valid && out_ready))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles == QUIET_LIMIT)
            begin
                $display("%0t: no request or result moved for %0d cycles", $time, QUIET_LIMIT);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial
    begin
        pace_t pace_plan[3];
        int    target;
        pace_plan = '{RECV_SLOW, SEND_SLOW, NO_IDLE};
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Requests while idle: tick, unused code, ignored note off
        queue_req(REQ_TICK, 15, 15, 15, 15, 127, 127, 127);
        queue_req(REQ_UNUSED, 0, 0, 0, 0, 0, 0, 0);
        queue_req(REQ_NOTE_OFF, 15, 0, 15, 0, 127, 127, 0);
        // Fast attack overshoots into decay, which ends the voice
        queue_req(REQ_NOTE_ON, 15, 15, 0, 15, 127, 127, 127);
        queue_req(REQ_NOTE_OFF, 0, 0, 0, 0, 0, 127, 127);
        queue_req(REQ_TICK, 0, 0, 0, 0, 0, 127, 127);
        queue_req(REQ_TICK, 0, 0, 0, 0, 0, 127, 127);
        queue_req(REQ_TICK, 0, 0, 0, 0, 0, 127, 127);
        // Decay from the peak into sustain, then note off with zero release
        queue_req(REQ_NOTE_ON, 0, 5, 7, 0, 127, 127, 127);
        queue_req(REQ_TICK, 15, 15, 15, 15, 0, 127, 127);
        queue_req(REQ_TICK, 0, 0, 0, 0, 0, 127, 127);
        queue_req(REQ_TICK, 0, 0, 0, 0, 0, 127, 127);
        queue_req(REQ_NOTE_OFF, 0, 0, 0, 0, 0, 127, 127);
        queue_req(REQ_TICK, 0, 0, 0, 0, 0, 127, 127);
        // Attack straight to sustain, release, then retrigger while sounding
        queue_req(REQ_NOTE_ON, 9, 0, 12, 3, 64, 0, 127);
        queue_req(REQ_TICK, 0, 0, 0, 0, 0, 127, 0);
        queue_req(REQ_TICK, 0, 0, 0, 0, 0, 0, 127);
        queue_req(REQ_TICK, 0, 0, 0, 0, 0, 127, 127);
        queue_req(REQ_NOTE_OFF, 0, 0, 0, 0, 0, 127, 127);
        queue_req(REQ_UNUSED, 15, 15, 15, 15, 127, 127, 127);
        queue_req(REQ_TICK, 0, 0, 0, 0, 0, 127, 127);
        queue_req(REQ_NOTE_ON, 0, 0, 2, 15, 127, 127, 127);
        queue_req(REQ_TICK, 0, 0, 0, 0, 0, 127, 127);
        queue_req(REQ_NOTE_OFF, 0, 0, 0, 0, 0, 127, 127);
        queue_req(REQ_TICK, 0, 0, 0, 0, 0, 127, 127);
        wait_drained();

        // Random traffic under each pacing, each phase opening with a long output stall
        for (int p = 0; p < 3; p++)
        begin
            @(posedge clk);
            pace = pace_plan[p];
            hold_requests++;
            target = queued_count + PHASE_ITEMS;
            while (queued_count < target)
            begin
                if ($urandom_range(99) < 80)
                    queue_note_sequence();
                else
                    queue_random(REQ_W'($urandom_range(3)));
            end
            wait_drained();
        end

        repeat (DRAIN_WAIT) @(negedge clk);
        $display("Checked %0d results for %0d requests", results_seen, accepted_count);
        $display("Mix: %0d ticks, %0d note on, %0d note off, %0d unused codes",
                 kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3]);
        $display("Traffic ran slow receiver, slow sender and full rate, each with a long stall");
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
